// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Each macro expects signals clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock edge, off during reset.
`define HFF_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property whose consequent holds in the cycle after the antecedent.
`define HFF_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/hff_pkg.sv =====
// Shared types, widths and constants for the haptic force field block.
// No dependencies; every module file imports this package.
package hff_pkg;

    localparam int VALUE_WIDTH = 20;
    localparam int FRAC_BITS   = 12;
    localparam int CFG_W       = 3 * VALUE_WIDTH;
    localparam int CFG_IDX_W   = 3;
    localparam int RAD_W       = VALUE_WIDTH - 1;
    localparam int OFS_W       = VALUE_WIDTH + 1;
    localparam int DIST_W      = 2 * OFS_W + 2;
    localparam int PROD_W      = OFS_W + VALUE_WIDTH;
    localparam int BASE_W      = VALUE_WIDTH + FRAC_BITS;
    localparam int ACC_W       = ((PROD_W > BASE_W) ? PROD_W : BASE_W) + 2;
    localparam int F_W         = ACC_W - FRAC_BITS;
    localparam int S_W         = 2 * F_W;
    localparam int R_W         = F_W;
    localparam int RM_W        = R_W + 3;
    localparam int LIMIT_WHOLE = 10;
    localparam int LIM_W       = FRAC_BITS + 4;
    localparam int DV_W        = F_W + LIM_W;
    localparam longint LIMIT   = longint'(LIMIT_WHOLE) <<< FRAC_BITS;
    localparam logic [S_W-1:0] LIMIT_SQ = S_W'(LIMIT * LIMIT);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACTIVE,
        REG_ORIGIN,
        REG_RADIUS,
        REG_BASE,
        REG_GAIN_X,
        REG_GAIN_Y,
        REG_GAIN_Z
    } cfg_reg_t;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] pos_z;
        logic signed [VALUE_WIDTH-1:0] pos_y;
        logic signed [VALUE_WIDTH-1:0] pos_x;
    } hff_in_t;

    typedef struct packed {
        logic                          was_clamped;
        logic                          in_range;
        logic signed [VALUE_WIDTH-1:0] force_z;
        logic signed [VALUE_WIDTH-1:0] force_y;
        logic signed [VALUE_WIDTH-1:0] force_x;
    } hff_out_t;

    typedef struct packed {
        logic                  active;
        logic [CFG_W-1:0]      origin;
        logic [RAD_W-1:0]      radius;
        logic [CFG_W-1:0]      base;
        logic [2:0][CFG_W-1:0] gain;
    } hff_cfg_t;

    // Per-item sideband that rides along the magnitude and divide pipes
    typedef struct packed {
        logic                in_range;
        logic                clamped;
        logic [2:0][F_W-1:0] f;
    } hff_side_t;

    function automatic logic signed [VALUE_WIDTH-1:0] lane(input logic [CFG_W-1:0] p,
                                                           input int k);
        return p[k*VALUE_WIDTH +: VALUE_WIDTH];
    endfunction

endpackage

// ===== hw/rtl/hff_front.sv =====
// Offset, range test, gain matrix, rounding, force magnitude squared and clamp test.
// Six register stages; depends on hff_pkg.
module hff_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              valid_i,
    input  hff_pkg::hff_in_t  in_i,
    input  hff_pkg::hff_cfg_t cfg_i,
    output logic              valid_o,
    output hff_pkg::hff_side_t side_o,
    output logic [hff_pkg::S_W-1:0] s_o
);
    import hff_pkg::*;

    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);

    logic [5:0] vld_reg;

    // stage 1
    logic                    act1_reg;
    logic signed [OFS_W-1:0] d1_reg [3];
    logic signed [OFS_W-1:0] d1_next [3];
    // stage 2
    logic                       act2_reg;
    logic signed [2*OFS_W-1:0]  sq2_reg [3];
    logic signed [PROD_W-1:0]   pr2_reg [3][3];
    logic signed [BASE_W-1:0]   base2_reg [3];
    logic [2*RAD_W-1:0]         r2_reg;
    // stage 3
    logic                    inr3_reg;
    logic signed [ACC_W-1:0] acc3_reg [3];
    logic signed [ACC_W-1:0] acc3_next [3];
    logic [DIST_W-1:0]       dist_next;
    // stage 4
    logic                    inr4_reg;
    logic signed [F_W-1:0]   f4_reg [3];
    logic signed [ACC_W-1:0] rnd [3];
    // stage 5
    logic                    inr5_reg;
    logic signed [F_W-1:0]   f5_reg [3];
    logic signed [S_W-1:0]   sq5_reg [3];
    // stage 6
    logic                    inr6_reg;
    logic                    clamp6_reg;
    logic signed [F_W-1:0]   f6_reg [3];
    logic [S_W-1:0]          s6_reg;
    logic [S_W-1:0]          s_next;

    always_comb
    begin
        d1_next[0] = OFS_W'(in_i.pos_x) - OFS_W'(lane(cfg_i.origin, 0));
        d1_next[1] = OFS_W'(in_i.pos_y) - OFS_W'(lane(cfg_i.origin, 1));
        d1_next[2] = OFS_W'(in_i.pos_z) - OFS_W'(lane(cfg_i.origin, 2));
    end

    always_comb
    begin
        dist_next = DIST_W'($unsigned(sq2_reg[0])) + DIST_W'($unsigned(sq2_reg[1]))
                  + DIST_W'($unsigned(sq2_reg[2]));
        for (int i = 0; i < 3; i++)
        begin
            acc3_next[i] = ACC_W'(base2_reg[i]) + ACC_W'(pr2_reg[i][0])
                         + ACC_W'(pr2_reg[i][1]) + ACC_W'(pr2_reg[i][2]);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rnd[i] = acc3_reg[i] + HALF;
        end
        s_next = $unsigned(sq5_reg[0]) + $unsigned(sq5_reg[1]) + $unsigned(sq5_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[4:0], valid_i};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            act1_reg <= cfg_i.active;
            d1_reg   <= d1_next;

            act2_reg <= act1_reg;
            r2_reg   <= cfg_i.radius * cfg_i.radius;
            for (int i = 0; i < 3; i++)
            begin
                sq2_reg[i]   <= d1_reg[i] * d1_reg[i];
                base2_reg[i] <= {lane(cfg_i.base, i), FRAC_BITS'(0)};
                for (int j = 0; j < 3; j++)
                begin
                    pr2_reg[i][j] <= d1_reg[j] * lane(cfg_i.gain[i], j);
                end
            end

            inr3_reg <= act2_reg && (dist_next <= DIST_W'(r2_reg));
            acc3_reg <= acc3_next;

            inr4_reg <= inr3_reg;
            for (int i = 0; i < 3; i++)
            begin
                f4_reg[i] <= inr3_reg ? F_W'(rnd[i] >>> FRAC_BITS) : '0;
            end

            inr5_reg <= inr4_reg;
            f5_reg   <= f4_reg;
            for (int i = 0; i < 3; i++)
            begin
                sq5_reg[i] <= f4_reg[i] * f4_reg[i];
            end

            inr6_reg   <= inr5_reg;
            clamp6_reg <= inr5_reg && (s_next > LIMIT_SQ);
            f6_reg     <= f5_reg;
            s6_reg     <= s_next;
        end
    end

    always_comb
    begin
        valid_o         = vld_reg[5];
        side_o.in_range = inr6_reg;
        side_o.clamped  = clamp6_reg;
        for (int i = 0; i < 3; i++)
        begin
            side_o.f[i] = f6_reg[i];
        end
        s_o = s6_reg;
    end

endmodule

// ===== hw/rtl/hff_sqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
// Carries the item sideband alongside; depends on hff_pkg.
module hff_sqrt (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  logic                    valid_i,
    input  hff_pkg::hff_side_t      side_i,
    input  logic [hff_pkg::S_W-1:0] s_i,
    output logic                    valid_o,
    output hff_pkg::hff_side_t      side_o,
    output logic [hff_pkg::R_W-1:0] m_o
);
    import hff_pkg::*;

    logic            vld_reg  [R_W];
    hff_side_t       side_reg [R_W];
    logic [S_W-1:0]  s_reg    [R_W];
    logic [RM_W-1:0] rem_reg  [R_W];
    logic [R_W-1:0]  root_reg [R_W];

    for (genvar k = 0; k < R_W; k++)
    begin : g_stage
        logic            vld_in;
        hff_side_t       side_in;
        logic [S_W-1:0]  s_in;
        logic [RM_W-1:0] rem_in;
        logic [R_W-1:0]  root_in;
        logic [RM_W-1:0] cat;
        logic [RM_W-1:0] trial;
        logic [RM_W-1:0] rem_next;
        logic [R_W-1:0]  root_next;

        if (k == 0)
        begin : g_first
            assign vld_in  = valid_i;
            assign side_in = side_i;
            assign s_in    = s_i;
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else
        begin : g_rest
            assign vld_in  = vld_reg[k-1];
            assign side_in = side_reg[k-1];
            assign s_in    = s_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        // bring down the next two radicand bits and try root*4+1
        always_comb
        begin
            cat   = {rem_in[RM_W-3:0], s_in[S_W-1-2*k -: 2]};
            trial = RM_W'({root_in, 2'b01});
            if (cat >= trial)
            begin
                rem_next  = cat - trial;
                root_next = {root_in[R_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = cat;
                root_next = {root_in[R_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                side_reg[k] <= side_in;
                s_reg[k]    <= s_in;
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
            end
        end
    end

    assign valid_o = vld_reg[R_W-1];
    assign side_o  = side_reg[R_W-1];
    assign m_o     = root_reg[R_W-1];

endmodule

// ===== hw/rtl/hff_div.sv =====
// Pipelined restoring divide of |f| * limit by the magnitude, one quotient
// bit per stage, after one stage that forms the dividends. Depends on hff_pkg.
module hff_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  logic                    valid_i,
    input  hff_pkg::hff_side_t      side_i,
    input  logic [hff_pkg::R_W-1:0] m_i,
    output logic                    valid_o,
    output hff_pkg::hff_side_t      side_o,
    output logic [2:0][hff_pkg::LIM_W-1:0] q_o
);
    import hff_pkg::*;

    logic                   pre_vld_reg;
    hff_side_t              pre_side_reg;
    logic [R_W-1:0]         pre_m_reg;
    logic [2:0][DV_W-1:0]   pre_dv_reg;
    logic [2:0][DV_W-1:0]   dv_next;
    logic [F_W-1:0]         mag;

    logic                   vld_reg  [LIM_W];
    hff_side_t              side_reg [LIM_W];
    logic [R_W-1:0]         m_reg    [LIM_W];
    logic [2:0][DV_W-1:0]   dv_reg   [LIM_W];
    logic [2:0][R_W-1:0]    rem_reg  [LIM_W];
    logic [2:0][LIM_W-1:0]  q_reg    [LIM_W];

    always_comb
    begin
        mag = '0;
        for (int i = 0; i < 3; i++)
        begin
            mag        = side_i.f[i][F_W-1] ? (F_W'(0) - side_i.f[i]) : side_i.f[i];
            dv_next[i] = DV_W'(mag) * DV_W'(LIMIT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            pre_vld_reg <= valid_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pre_side_reg <= side_i;
            pre_m_reg    <= m_i;
            pre_dv_reg   <= dv_next;
        end
    end

    for (genvar k = 0; k < LIM_W; k++)
    begin : g_stage
        logic                  vld_in;
        hff_side_t             side_in;
        logic [R_W-1:0]        m_in;
        logic [2:0][DV_W-1:0]  dv_in;
        logic [2:0][R_W-1:0]   rem_in;
        logic [2:0][LIM_W-1:0] q_in;
        logic [2:0][R_W-1:0]   rem_next;
        logic [2:0][LIM_W-1:0] q_next;
        logic [R_W:0]          cat;

        if (k == 0)
        begin : g_first
            assign vld_in  = pre_vld_reg;
            assign side_in = pre_side_reg;
            assign m_in    = pre_m_reg;
            assign dv_in   = pre_dv_reg;
            // the quotient fits LIM_W bits, so the top part starts below m
            always_comb
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rem_in[i] = R_W'(pre_dv_reg[i][DV_W-1:LIM_W]);
                end
            end
            assign q_in = '0;
        end
        else
        begin : g_rest
            assign vld_in  = vld_reg[k-1];
            assign side_in = side_reg[k-1];
            assign m_in    = m_reg[k-1];
            assign dv_in   = dv_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign q_in    = q_reg[k-1];
        end

        always_comb
        begin
            cat = '0;
            for (int i = 0; i < 3; i++)
            begin
                cat = {rem_in[i], dv_in[i][LIM_W-1-k]};
                if (cat >= {1'b0, m_in})
                begin
                    rem_next[i] = R_W'(cat - {1'b0, m_in});
                    q_next[i]   = {q_in[i][LIM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[i] = R_W'(cat);
                    q_next[i]   = {q_in[i][LIM_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                side_reg[k] <= side_in;
                m_reg[k]    <= m_in;
                dv_reg[k]   <= dv_in;
                rem_reg[k]  <= rem_next;
                q_reg[k]    <= q_next;
            end
        end
    end

    assign valid_o = vld_reg[LIM_W-1];
    assign side_o  = side_reg[LIM_W-1];
    assign q_o     = q_reg[LIM_W-1];

endmodule

// ===== hw/rtl/haptic_force_field.sv =====
// haptic_force_field: one result per transaction, one transaction per cycle while not stalled.
// Pipeline: 6 front stages, 31 square root stages, 17 divide stages and the output register.
// The whole pipe holds while the output register is full and stalled.
// Reset clears the configuration registers and all valid bits.
module haptic_force_field (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  hff_pkg::hff_in_t              in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output hff_pkg::hff_out_t             out_data,
    input  logic                          cfg_we,
    input  logic [hff_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hff_pkg::CFG_W-1:0]     cfg_data
);
    import hff_pkg::*;

    localparam logic signed [F_W:0] VMAX = (F_W+1)'((longint'(1) <<< (VALUE_WIDTH-1)) - 1);
    localparam logic signed [F_W:0] VMIN = -VMAX - (F_W+1)'(1);

    hff_cfg_t cfg_reg;
    logic     adv;

    logic                  fr_valid;
    hff_side_t             fr_side;
    logic [S_W-1:0]        fr_s;
    logic                  sq_valid;
    hff_side_t             sq_side;
    logic [R_W-1:0]        sq_m;
    logic                  dv_valid;
    hff_side_t             dv_side;
    logic [2:0][LIM_W-1:0] dv_q;

    logic                          out_valid_reg;
    hff_out_t                      out_data_reg;
    logic signed [VALUE_WIDTH-1:0] res [3];
    logic signed [F_W:0]           v;

    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_ACTIVE: cfg_reg.active  <= cfg_data[0];
                REG_ORIGIN: cfg_reg.origin  <= cfg_data;
                REG_RADIUS: cfg_reg.radius  <= cfg_data[RAD_W-1:0];
                REG_BASE:   cfg_reg.base    <= cfg_data;
                REG_GAIN_X: cfg_reg.gain[0] <= cfg_data;
                REG_GAIN_Y: cfg_reg.gain[1] <= cfg_data;
                REG_GAIN_Z: cfg_reg.gain[2] <= cfg_data;
                default:    ;
            endcase
        end
    end

    hff_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .valid_i (in_valid),
        .in_i    (in_data),
        .cfg_i   (cfg_reg),
        .valid_o (fr_valid),
        .side_o  (fr_side),
        .s_o     (fr_s)
    );

    hff_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .valid_i (fr_valid),
        .side_i  (fr_side),
        .s_i     (fr_s),
        .valid_o (sq_valid),
        .side_o  (sq_side),
        .m_o     (sq_m)
    );

    hff_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .valid_i (sq_valid),
        .side_i  (sq_side),
        .m_i     (sq_m),
        .valid_o (dv_valid),
        .side_o  (dv_side),
        .q_o     (dv_q)
    );

    // pick scaled or plain component, restore sign, saturate
    always_comb
    begin
        v = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (dv_side.clamped)
            begin
                v = $signed((F_W+1)'(dv_q[i]));
                if (dv_side.f[i][F_W-1])
                begin
                    v = -v;
                end
            end
            else
            begin
                v = (F_W+1)'($signed(dv_side.f[i]));
            end
            if (v > VMAX)
            begin
                res[i] = VALUE_WIDTH'(VMAX);
            end
            else if (v < VMIN)
            begin
                res[i] = VALUE_WIDTH'(VMIN);
            end
            else
            begin
                res[i] = VALUE_WIDTH'(v);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg.force_x     <= res[0];
            out_data_reg.force_y     <= res[1];
            out_data_reg.force_z     <= res[2];
            out_data_reg.in_range    <= dv_side.in_range;
            out_data_reg.was_clamped <= dv_side.clamped;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== hw/rtl/hff_checker.sv =====
// Port-level checks for haptic_force_field, bound to the top level.
// Depends on hff_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hff_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  hff_pkg::hff_out_t             out_data
);
    import hff_pkg::*;

    // a stalled transaction holds its value
    `HFF_CHECK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled output changed")

    // out of range or inactive gives zero force and no clamp
    `HFF_CHECK(a_zero_force, out_valid && !out_data.in_range |-> out_data.force_x == '0 && out_data.force_y == '0 && out_data.force_z == '0 && !out_data.was_clamped, "nonzero force outside the field")

    `HFF_CHECK(a_clamp_range, out_valid && out_data.was_clamped |-> out_data.in_range, "clamp flagged outside the field")

    // scaled components never exceed the force limit
    `HFF_CHECK(a_clamp_bound, out_valid && out_data.was_clamped |-> $signed(out_data.force_x) <= LIMIT && $signed(out_data.force_x) >= -LIMIT && $signed(out_data.force_y) <= LIMIT && $signed(out_data.force_y) >= -LIMIT && $signed(out_data.force_z) <= LIMIT && $signed(out_data.force_z) >= -LIMIT, "clamped force beyond limit")

endmodule

bind haptic_force_field hff_checker u_hff_checker (.*);
